FILE: rtl/mtvm_pkg.sv
// Shared types and constants for the multi-target value mapper
// Item structs, datapath command and status structs, fixed scale constants
// No dependencies
`default_nettype none

package mtvm_pkg;

    // fixed curve geometry and arithmetic widths
    localparam int CURVE_POINTS = 257;
    localparam int CRV_AW       = 9;
    localparam int FRAC_W       = 7;
    localparam int MAX_RESULTS  = 16;
    localparam int MUL_W        = 20;
    localparam int PROD_W       = 40;
    localparam int DIV_W        = 35;
    localparam int TERM_W       = DIV_W + 1;

    localparam logic [15:0] FULL_SCALE  = 16'd32768;
    localparam logic [15:0] OFFSET_ZERO = 16'd16384;
    localparam logic [10:0] GAIN_UNITY  = 11'd256;
    localparam logic [7:0]  SEG_STEPS   = 8'd128;
    localparam logic [14:0] SHIFT_BIAS  = 15'd32767;
    localparam logic [7:0]  GAIN_BIAS   = 8'd255;
    localparam logic [6:0]  FRAC_MAX    = 7'd127;

    // action codes
    localparam logic [1:0] ACT_SEND     = 2'd0;
    localparam logic [1:0] ACT_WR_CURVE = 2'd1;
    localparam logic [1:0] ACT_WR_SLOT  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_GAIN   = 2'd0;
    localparam logic [1:0] CFG_QUANT  = 2'd1;
    localparam logic [1:0] CFG_OFFSET = 2'd2;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] value;
        logic [8:0]  index;
        logic [15:0] point_value;
        logic [15:0] slot_min;
        logic [15:0] slot_max;
        logic [7:0]  slot_target;
        logic        slot_enable;
        logic [15:0] frame_offset;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  slot_number;
        logic [7:0]  target_ctl;
        logic [15:0] mapped_value;
        logic [15:0] event_offset;
        logic        last;
    } t_out_item;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        DP_NOP,
        DP_LOAD,
        DP_WR_CURVE,
        DP_WR_SLOT,
        DP_RD0,
        DP_RD1,
        DP_MUL1,
        DP_ACC,
        DP_SKIP,
        DP_GAIN,
        DP_GCLP,
        DP_QMUL,
        DP_QCLP,
        DP_RMUL,
        DP_SHR,
        DP_DSTART,
        DP_DIV,
        DP_FIN
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   crv_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic cur_qual;
        logic slot_last;
        logic res_last;
        logic quant_on;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

FILE: rtl/mtvm_ctrl.sv
// Controller state machine for the multi-target value mapper
// Sequences curve lookups, the per-slot arithmetic and the divider
// Depends on mtvm_pkg
`default_nettype none

module mtvm_ctrl
    import mtvm_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire logic [1:0] i_action,
    output logic            o_in_ready,
    output t_dp_cmd         o_cmd,
    input  wire t_dp_status i_status
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_MUL1,
        S_ACC,
        S_SCAN,
        S_GAIN,
        S_GCLP,
        S_QMUL,
        S_QCLP,
        S_RMUL,
        S_SHR,
        S_DSTART,
        S_DIV,
        S_FIN
    } t_state;

    t_state r_state, n_state;
    logic   r_crv_sel, n_crv_sel;

    // next state and command decode
    always_comb begin
        n_state     = r_state;
        n_crv_sel   = r_crv_sel;
        o_cmd.op    = DP_NOP;
        o_cmd.crv_sel = r_crv_sel;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    unique case (i_action)
                        ACT_SEND: begin
                            o_cmd.op  = DP_LOAD;
                            n_crv_sel = 1'b0;
                            n_state   = S_RD0;
                        end
                        ACT_WR_CURVE: o_cmd.op = DP_WR_CURVE;
                        ACT_WR_SLOT:  o_cmd.op = DP_WR_SLOT;
                        default:      o_cmd.op = DP_NOP;
                    endcase
                end
            end
            S_RD0: begin
                o_cmd.op = DP_RD0;
                n_state  = S_RD1;
            end
            S_RD1: begin
                o_cmd.op = DP_RD1;
                n_state  = S_MUL1;
            end
            S_MUL1: begin
                o_cmd.op = DP_MUL1;
                n_state  = S_ACC;
            end
            S_ACC: begin
                o_cmd.op = DP_ACC;
                if (!r_crv_sel) begin
                    n_crv_sel = 1'b1;
                    n_state   = S_RD0;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.cur_qual) begin
                    n_state = S_GAIN;
                end else if (i_status.slot_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.op = DP_SKIP;
                end
            end
            S_GAIN: begin
                o_cmd.op = DP_GAIN;
                n_state  = S_GCLP;
            end
            S_GCLP: begin
                o_cmd.op = DP_GCLP;
                n_state  = i_status.quant_on ? S_QMUL : S_RMUL;
            end
            S_QMUL: begin
                o_cmd.op = DP_QMUL;
                n_state  = S_QCLP;
            end
            S_QCLP: begin
                o_cmd.op = DP_QCLP;
                n_state  = S_RMUL;
            end
            S_RMUL: begin
                o_cmd.op = DP_RMUL;
                n_state  = i_status.quant_on ? S_DSTART : S_SHR;
            end
            S_SHR: begin
                o_cmd.op = DP_SHR;
                n_state  = S_FIN;
            end
            S_DSTART: begin
                o_cmd.op = DP_DSTART;
                n_state  = S_DIV;
            end
            S_DIV: begin
                o_cmd.op = DP_DIV;
                if (i_status.div_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold the finished value until the output register is free
                if (i_status.out_free) begin
                    o_cmd.op = DP_FIN;
                    n_state  = i_status.res_last ? S_IDLE : S_SCAN;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_crv_sel <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_crv_sel <= n_crv_sel;
        end
    end

    // a send starts with the normal curve lookup
    a_send_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_action == ACT_SEND) |=>
        (r_state == S_RD0 && !r_crv_sel))
        else $error("send did not start with the normal curve lookup");

    // the divider only runs with quantization on
    a_div_quant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_DSTART) |-> i_status.quant_on)
        else $error("divider started without quantization");

    // divider iterations follow the divider start
    a_div_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_DSTART) |=> (o_cmd.op == DP_DIV))
        else $error("divider start not followed by iterations");

endmodule

`default_nettype wire

FILE: rtl/mtvm_dp.sv
// Datapath for the multi-target value mapper
// Curve memory, slot table, config registers, shared multiplier, divider, output register
// Depends on mtvm_pkg
`default_nettype none

module mtvm_dp
    import mtvm_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_dp_cmd    i_cmd,
    input  wire t_in_item   i_item,
    input  wire logic       i_cfg_valid,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data,
    output t_dp_status      o_status,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CW = $clog2(DIV_W);

    // configuration registers
    logic [10:0] r_gain;
    logic [15:0] r_quant;
    logic [15:0] r_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain   <= GAIN_UNITY;
            r_quant  <= FULL_SCALE;
            r_offset <= OFFSET_ZERO;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_GAIN:   r_gain   <= i_cfg_data[10:0];
                CFG_QUANT:  r_quant  <= i_cfg_data;
                CFG_OFFSET: r_offset <= i_cfg_data;
                default:    r_gain   <= r_gain;
            endcase
        end
    end

    // quantization level divisor, at least one
    logic        quant_on;
    logic [14:0] lvl;
    assign quant_on = !r_quant[15];
    assign lvl = (r_quant[15:1] == 15'd0) ? 15'd1 : 15'(r_quant - 16'd1);

    // send item capture and slot walk
    logic [15:0]   r_value;
    logic [15:0]   r_frame;
    logic [SW-1:0] r_slot;
    logic [3:0]    r_cnt;

    // slot table
    logic [15:0] r_slot_low    [SLOT_COUNT];
    logic [15:0] r_slot_high   [SLOT_COUNT];
    logic [7:0]  r_slot_ctl    [SLOT_COUNT];
    logic [SLOT_COUNT-1:0] r_slot_linked;

    logic slot_wr;
    assign slot_wr = (i_cmd.op == DP_WR_SLOT) && (i_item.index < 9'(SLOT_COUNT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slot_low[i]  <= 16'd0;
                r_slot_high[i] <= FULL_SCALE;
                r_slot_ctl[i]  <= 8'd0;
            end
            r_slot_linked <= '0;
        end else if (slot_wr) begin
            r_slot_low[i_item.index[SW-1:0]]    <= i_item.slot_min;
            r_slot_high[i_item.index[SW-1:0]]   <= i_item.slot_max;
            r_slot_ctl[i_item.index[SW-1:0]]    <= i_item.slot_target;
            r_slot_linked[i_item.index[SW-1:0]] <= i_item.slot_enable;
        end
    end

    // per-slot qualification: linked with a nonzero target
    logic [SLOT_COUNT-1:0] qual;
    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            qual[i] = r_slot_linked[i] && (r_slot_ctl[i] != 8'd0);
        end
    end

    logic [SLOT_COUNT-1:0] qual_up;
    logic                  qual_above;
    logic                  res_last;
    assign qual_up    = (qual >> r_slot) >> 1;
    assign qual_above = |qual_up;
    assign res_last   = !qual_above || (r_cnt == 4'(MAX_RESULTS - 1));

    logic [15:0] cur_lo;
    logic [15:0] cur_hi;
    logic [7:0]  cur_ctl;
    logic        mirrored;
    logic [16:0] range;
    assign cur_lo   = r_slot_low[r_slot];
    assign cur_hi   = r_slot_high[r_slot];
    assign cur_ctl  = r_slot_ctl[r_slot];
    assign mirrored = !(cur_lo < cur_hi);
    assign range    = {1'b0, cur_hi} - {1'b0, cur_lo};

    // curve argument: the send value, or its mirror clipped at zero
    logic [16:0]      mir_x;
    logic             x_big;
    logic [14:0]      x15;
    logic [7:0]       seg;
    logic [6:0]       frac;
    logic [CRV_AW-1:0] addr0;
    logic [CRV_AW-1:0] addr1;
    logic [7:0]       wt0;
    logic [7:0]       wt1;

    assign mir_x = {1'b0, FULL_SCALE} - {1'b0, r_value};

    always_comb begin
        if (!i_cmd.crv_sel) begin
            x_big = r_value[15];
            x15   = r_value[14:0];
        end else if (mir_x[16]) begin
            x_big = 1'b0;
            x15   = 15'd0;
        end else begin
            x_big = mir_x[15];
            x15   = mir_x[14:0];
        end
    end

    assign seg   = x15[14:FRAC_W];
    assign frac  = x15[FRAC_W-1:0] & FRAC_MAX;
    assign addr0 = x_big ? CRV_AW'(CURVE_POINTS - 1) : {1'b0, seg};
    assign addr1 = x_big ? CRV_AW'(CURVE_POINTS - 1) : ({1'b0, seg} + CRV_AW'(1));
    assign wt0   = x_big ? SEG_STEPS : (SEG_STEPS - {1'b0, frac});
    assign wt1   = x_big ? 8'd0 : {1'b0, frac};

    // curve memory, entries not yet written read as the ramp
    logic [15:0]             r_crv_mem [CURVE_POINTS];
    logic [CURVE_POINTS-1:0] r_crv_valid;
    logic [15:0]             r_rd_data;
    logic                    r_rd_valid;
    logic [CRV_AW-1:0]       r_rd_addr;
    logic [CRV_AW-1:0]       rd_addr;
    logic                    crv_wr;
    logic [15:0]             rd_word;

    assign crv_wr  = (i_cmd.op == DP_WR_CURVE) && (i_item.index < CRV_AW'(CURVE_POINTS));
    assign rd_addr = (i_cmd.op == DP_RD0) ? addr0 : addr1;

    always_ff @(posedge i_clk) begin
        if (crv_wr) begin
            r_crv_mem[i_item.index] <= i_item.point_value;
        end
        r_rd_data <= r_crv_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crv_valid <= '0;
        end else if (crv_wr) begin
            r_crv_valid[i_item.index] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= r_crv_valid[rd_addr];
        r_rd_addr  <= rd_addr;
    end

    assign rd_word = r_rd_valid ? r_rd_data : {r_rd_addr, 7'd0};

    // curve results for both directions
    logic [15:0] r_y_norm;
    logic [15:0] r_y_mir;
    logic [22:0] r_acc;
    logic [22:0] acc_sum;
    logic [17:0] v0;

    assign v0 = mirrored ? ({2'b0, FULL_SCALE} - {2'b0, r_y_mir}) : {2'b0, r_y_norm};

    // shared multiplier, one product register
    logic signed [PROD_W-1:0] r_prod;
    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [MUL_W-1:0]  r_v;
    logic signed [MUL_W-1:0]  r_q;

    assign acc_sum = r_acc + r_prod[22:0];

    always_comb begin
        unique case (i_cmd.op)
            DP_RD1: begin
                mul_a = $signed({4'b0, rd_word});
                mul_b = $signed({12'b0, wt0});
            end
            DP_MUL1: begin
                mul_a = $signed({4'b0, rd_word});
                mul_b = $signed({12'b0, wt1});
            end
            DP_GAIN: begin
                mul_a = $signed({{2{v0[17]}}, v0});
                mul_b = $signed({9'b0, r_gain});
            end
            DP_QMUL: begin
                mul_a = r_v;
                mul_b = $signed({5'b0, lvl});
            end
            DP_RMUL: begin
                mul_a = $signed({{3{range[16]}}, range});
                mul_b = quant_on ? r_q : r_v;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // truncating shifts of the product toward zero
    logic signed [PROD_W-1:0] prod_sh8;
    logic signed [PROD_W-1:0] prod_sh15;
    logic signed [PROD_W-1:0] lvl_wide;
    assign prod_sh8  = $signed(r_prod + (r_prod[PROD_W-1] ? PROD_W'(GAIN_BIAS)
                                                          : PROD_W'(0))) >>> 8;
    assign prod_sh15 = $signed(r_prod + (r_prod[PROD_W-1] ? PROD_W'(SHIFT_BIAS)
                                                          : PROD_W'(0))) >>> 15;
    assign lvl_wide  = PROD_W'(lvl);

    // restoring divider, one quotient bit per cycle
    logic [DIV_W-1:0]  r_dnum;
    logic [14:0]       r_rem;
    logic [CW-1:0]     r_dcnt;
    logic              r_dneg;
    logic [15:0]       rem_sh;
    logic [15:0]       rem_sub;
    logic              rem_ge;
    logic [PROD_W-1:0] prod_mag;

    assign rem_sh   = {r_rem, r_dnum[DIV_W-1]};
    assign rem_sub  = rem_sh - {1'b0, lvl};
    assign rem_ge   = (rem_sh >= {1'b0, lvl});
    assign prod_mag = r_prod[PROD_W-1] ? (PROD_W'(0) - r_prod) : r_prod;

    // final offset and clamp
    logic signed [TERM_W-1:0] r_t;
    logic signed [TERM_W-1:0] quot;
    logic signed [TERM_W-1:0] term;
    logic signed [PROD_W-1:0] sum;
    logic [15:0]              mapped;

    assign quot = r_dneg ? (TERM_W'(0) - {1'b0, r_dnum}) : {1'b0, r_dnum};
    assign term = quant_on ? quot : r_t;
    assign sum  = PROD_W'(cur_lo) + PROD_W'(term) + PROD_W'(r_offset) - PROD_W'(OFFSET_ZERO);

    always_comb begin
        if (sum[PROD_W-1]) begin
            mapped = 16'd0;
        end else if (sum > PROD_W'(FULL_SCALE)) begin
            mapped = FULL_SCALE;
        end else begin
            mapped = sum[15:0];
        end
    end

    // work registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_LOAD: begin
                r_value <= i_item.value;
                r_frame <= i_item.frame_offset;
            end
            DP_RD1:  r_prod <= mul_p;
            DP_MUL1: begin
                r_acc  <= r_prod[22:0];
                r_prod <= mul_p;
            end
            DP_ACC: begin
                if (i_cmd.crv_sel) begin
                    r_y_mir <= acc_sum[22:FRAC_W];
                end else begin
                    r_y_norm <= acc_sum[22:FRAC_W];
                end
            end
            DP_GAIN: r_prod <= mul_p;
            DP_GCLP: begin
                if (prod_sh8 > $signed(PROD_W'(FULL_SCALE))) begin
                    r_v <= MUL_W'(FULL_SCALE);
                end else begin
                    r_v <= prod_sh8[MUL_W-1:0];
                end
            end
            DP_QMUL: r_prod <= mul_p;
            DP_QCLP: begin
                if (prod_sh15 > lvl_wide) begin
                    r_q <= MUL_W'(lvl);
                end else begin
                    r_q <= prod_sh15[MUL_W-1:0];
                end
            end
            DP_RMUL: r_prod <= mul_p;
            DP_SHR:  r_t <= prod_sh15[TERM_W-1:0];
            DP_DSTART: begin
                r_dneg <= r_prod[PROD_W-1];
                r_dnum <= prod_mag[DIV_W-1:0];
                r_rem  <= 15'd0;
                r_dcnt <= CW'(DIV_W - 1);
            end
            DP_DIV: begin
                r_rem  <= rem_ge ? rem_sub[14:0] : rem_sh[14:0];
                r_dnum <= {r_dnum[DIV_W-2:0], rem_ge};
                r_dcnt <= r_dcnt - CW'(1);
            end
            default: r_acc <= r_acc;
        endcase
    end

    // slot walk counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot <= '0;
            r_cnt  <= 4'd0;
        end else begin
            unique case (i_cmd.op)
                DP_LOAD: begin
                    r_slot <= '0;
                    r_cnt  <= 4'd0;
                end
                DP_SKIP: r_slot <= r_slot + SW'(1);
                DP_FIN: begin
                    r_slot <= r_slot + SW'(1);
                    r_cnt  <= r_cnt + 4'd1;
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // output register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.op == DP_FIN) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == DP_FIN) begin
            o_out_item.slot_number  <= 4'(r_slot);
            o_out_item.target_ctl   <= cur_ctl - 8'd1;
            o_out_item.mapped_value <= mapped;
            o_out_item.event_offset <= r_frame;
            o_out_item.last         <= res_last;
        end
    end

    assign o_out_valid = r_out_valid;

    // status back to the controller
    assign o_status.cur_qual  = qual[r_slot];
    assign o_status.slot_last = (r_slot == SW'(SLOT_COUNT - 1));
    assign o_status.res_last  = res_last;
    assign o_status.quant_on  = quant_on;
    assign o_status.div_last  = (r_dcnt == CW'(0));
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    // partial remainder stays below the divisor
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_DIV) |-> (r_rem < lvl))
        else $error("divider remainder not below divisor");

    // a result is never loaded over one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_FIN) |-> (!r_out_valid || i_out_ready))
        else $error("result overwrote a waiting item");

    // gain stage output is clamped to full scale
    a_gain_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_GCLP) |=> (r_v <= $signed(MUL_W'(FULL_SCALE))))
        else $error("gain stage exceeded full scale");

endmodule

`default_nettype wire

FILE: rtl/multi_target_value_mapper_unit.sv
// Top level of the multi-target value mapper
// Joins the controller and the datapath, drives the config ready
// Depends on mtvm_pkg, mtvm_ctrl, mtvm_dp
//
//   channel  direction  handshake                  payload
//   in       input      i_in_valid / o_in_ready    i_in_item (t_in_item)
//   out      output     o_out_valid / i_out_ready  o_out_item (t_out_item)
//   cfg      input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Write items are taken in the idle state. A send item runs two curve lookups
// (each two reads of the curve memory through the shared multiplier), then skips
// each slot without a destination; each result runs the gain and range multiplies,
// with quantization also the level multiply and the 35-step restoring divider.
// Reset is synchronous and active low; the curve needs no clearing pass.
// The next slot is computed while a result waits in the output register; a
// stalled output holds the block only when the following result is ready.
`default_nettype none

module multi_target_value_mapper_unit
    import mtvm_pkg::*;
#(
    parameter int SLOT_COUNT = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_item,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_item,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_dp_cmd    cmd;
    t_dp_status status;

    // config writes are taken at any time
    assign o_cfg_ready = 1'b1;

    mtvm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_in_item.action),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_status   (status)
    );

    mtvm_dp #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_item      (i_in_item),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

`default_nettype wire
